// ===== hdl/dwpid_pkg.sv =====
// Package for the dual-wheel incremental PID drive block.
// Holds widths, register codes, reset values and the structs that pass between modules.
// No dependencies.
package dwpid_pkg;

	localparam int EncW     = 32;
	localparam int TgtW     = 16;
	localparam int GainW    = 16;
	localparam int LimW     = 8;
	localparam int DrvW     = 9;
	localparam int PwmW     = 8;
	localparam int DerrW    = EncW + 1;
	localparam int ProdW    = GainW + 1 + DerrW;
	localparam int AccW     = ProdW + 2;
	localparam int QuoW     = AccW + 1;
	localparam int DivSteps = AccW / 2;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_GAIN_DIV = 3'd3,
		REG_MAX_OUT  = 3'd4
	} dwpid_reg_t;

	localparam logic [GainW-1:0] GainPRst   = 16'd20;
	localparam logic [GainW-1:0] GainIRst   = 16'd0;
	localparam logic [GainW-1:0] GainDRst   = 16'd0;
	localparam logic [GainW-1:0] GainDivRst = 16'd120;
	localparam logic [LimW-1:0]  MaxOutRst  = 8'd255;

	typedef struct packed {
		logic [GainW-1:0] gain_p;
		logic [GainW-1:0] gain_i;
		logic [GainW-1:0] gain_d;
		logic [GainW-1:0] gain_divisor;
		logic [LimW-1:0]  max_output;
	} dwpid_cfg_t;

	typedef struct packed {
		logic signed [EncW-1:0] enc_left;
		logic signed [EncW-1:0] enc_right;
		logic signed [TgtW-1:0] target_left;
		logic signed [TgtW-1:0] target_right;
		logic                   moving;
	} dwpid_item_t;

	typedef struct packed {
		logic signed [DrvW-1:0] drive_left;
		logic signed [DrvW-1:0] drive_right;
	} dwpid_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dwpid_stat_t;

endpackage

// ===== hdl/dwpid_if.sv =====
// Channel interfaces of the PID drive block: input items, results and register writes.
// Depends on dwpid_pkg for field widths.
interface dwpid_in_if import dwpid_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [EncW-1:0] enc_left;
	logic signed [EncW-1:0] enc_right;
	logic signed [TgtW-1:0] target_left;
	logic signed [TgtW-1:0] target_right;
	logic                   moving;

	modport source(output valid, enc_left, enc_right, target_left, target_right, moving,
		input ready);
	modport sink(input valid, enc_left, enc_right, target_left, target_right, moving,
		output ready);
endinterface

interface dwpid_out_if import dwpid_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [DrvW-1:0] drive_left;
	logic signed [DrvW-1:0] drive_right;
	logic [PwmW-1:0]        left_reverse;
	logic [PwmW-1:0]        left_forward;
	logic [PwmW-1:0]        right_reverse;
	logic [PwmW-1:0]        right_forward;

	modport source(output valid, drive_left, drive_right, left_reverse, left_forward,
		right_reverse, right_forward, input ready);
	modport sink(input valid, drive_left, drive_right, left_reverse, left_forward,
		right_reverse, right_forward, output ready);
endinterface

interface dwpid_cfg_if import dwpid_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/dwpid_cfg_regs.sv =====
// Configuration register file: gains, divisor and drive limit.
// Depends on dwpid_pkg for register codes and reset values.
module dwpid_cfg_regs import dwpid_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_idx,
	input  logic [CfgDataW-1:0] wr_data,
	output dwpid_cfg_t          cfg
);

	dwpid_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= GainPRst;
			cfg_q.gain_i       <= GainIRst;
			cfg_q.gain_d       <= GainDRst;
			cfg_q.gain_divisor <= GainDivRst;
			cfg_q.max_output   <= MaxOutRst;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_GAIN_P:   cfg_q.gain_p       <= wr_data;
				REG_GAIN_I:   cfg_q.gain_i       <= wr_data;
				REG_GAIN_D:   cfg_q.gain_d       <= wr_data;
				REG_GAIN_DIV: cfg_q.gain_divisor <= wr_data;
				REG_MAX_OUT:  cfg_q.max_output   <= wr_data[LimW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/dwpid_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle (restoring, radix 4).
// Depends on dwpid_pkg for widths; the divisor must be nonzero.
module dwpid_div import dwpid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AccW-1:0]  dividend,
	input  logic [GainW-1:0] divisor,
	output logic             done,
	output logic [AccW-1:0]  quotient
);

	logic [GainW-1:0]   rem_q;
	logic [AccW-1:0]    quo_q;
	logic [GainW-1:0]   den_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [GainW:0]   t1, t2;
	logic             ge1, ge2;
	logic [GainW-1:0] r1, r2;

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	always_comb begin
		t1  = {rem_q, quo_q[AccW-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? GainW'(t1 - {1'b0, den_q}) : t1[GainW-1:0];
		t2  = {r1, quo_q[AccW-2]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? GainW'(t2 - {1'b0, den_q}) : t2[GainW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivSteps - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[AccW-3:0], ge1, ge2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/dwpid_core.sv =====
// PID sequencer: per-wheel state, one shared multiplier with accumulator, divider control.
// Depends on dwpid_pkg and dwpid_div.
module dwpid_core import dwpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dwpid_cfg_t  cfg,
	input  logic        start,
	input  dwpid_item_t item,
	input  logic        ack,
	output dwpid_stat_t stat,
	output dwpid_res_t  res
);

	typedef enum logic [3:0] {
		S_IDLE, S_DELTA, S_ERR, S_MUL0, S_MUL1, S_MUL2, S_MUL3,
		S_ABS, S_DIV, S_NEG, S_CLAMP, S_DONE
	} state_t;

	state_t state_q;

	dwpid_item_t             item_q;
	logic                    wheel_q;
	logic [EncW-1:0]         delta_q;
	logic signed [EncW-1:0]  err_q;
	logic signed [DerrW-1:0] derr_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  acc_q;
	logic                    neg_q;
	logic signed [QuoW-1:0]  qs_q;
	logic signed [DrvW-1:0]  drv_q [2];

	logic [EncW-1:0]         prev_enc_q [2];
	logic signed [EncW-1:0]  prev_err_q [2];
	logic signed [EncW-1:0]  integ_q    [2];
	logic signed [DrvW-1:0]  last_q     [2];

	logic [EncW-1:0]         enc_sel;
	logic signed [TgtW-1:0]  tgt_sel;
	logic [GainW-1:0]        mul_a;
	logic signed [DerrW-1:0] mul_b;
	logic signed [ProdW-1:0] mul_res;
	logic                    div_start;
	logic [AccW-1:0]         div_dividend;
	logic [GainW-1:0]        div_den;
	logic                    div_done;
	logic [AccW-1:0]         div_quo;
	logic signed [QuoW-1:0]  sum_out;
	logic signed [QuoW-1:0]  lim_pos;
	logic signed [QuoW-1:0]  lim_neg;

	assign enc_sel = wheel_q ? item_q.enc_right : item_q.enc_left;
	assign tgt_sel = wheel_q ? item_q.target_right : item_q.target_left;

	always_comb begin
		mul_a = cfg.gain_p;
		mul_b = DerrW'(err_q);
		case (state_q)
			S_MUL1: begin
				mul_a = cfg.gain_d;
				mul_b = derr_q;
			end
			S_MUL2: begin
				mul_a = cfg.gain_i;
				mul_b = DerrW'(integ_q[wheel_q]);
			end
			default: ;
		endcase
	end

	assign mul_res = $signed({1'b0, mul_a}) * mul_b;

	assign div_start    = (state_q == S_ABS);
	assign div_dividend = acc_q[AccW-1] ? AccW'(-acc_q) : acc_q;
	assign div_den      = (cfg.gain_divisor == '0) ? GainW'(1) : cfg.gain_divisor;

	dwpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign sum_out = qs_q + QuoW'(last_q[wheel_q]);
	assign lim_pos = $signed({{(QuoW-LimW){1'b0}}, cfg.max_output});
	assign lim_neg = -lim_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wheel_q <= 1'b0;
			for (int w = 0; w < 2; w++) begin
				prev_enc_q[w] <= '0;
				prev_err_q[w] <= '0;
				integ_q[w]    <= '0;
				last_q[w]     <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						wheel_q <= 1'b0;
						state_q <= item.moving ? S_DELTA : S_DONE;
					end
				end
				S_DELTA: state_q <= S_ERR;
				S_ERR:   state_q <= S_MUL0;
				S_MUL0:  state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_ABS;
				S_ABS:   state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_NEG;
					end
				end
				S_NEG:   state_q <= S_CLAMP;
				S_CLAMP: begin
					prev_err_q[wheel_q] <= err_q;
					prev_enc_q[wheel_q] <= enc_sel;
					if (sum_out >= lim_pos) begin
						last_q[wheel_q] <= DrvW'(lim_pos);
					end else if (sum_out <= lim_neg) begin
						last_q[wheel_q] <= DrvW'(lim_neg);
					end else begin
						last_q[wheel_q]  <= DrvW'(sum_out);
						integ_q[wheel_q] <= integ_q[wheel_q] + err_q;
					end
					wheel_q <= 1'b1;
					state_q <= wheel_q ? S_DONE : S_DELTA;
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; the sequencer decides when each one is meaningful.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q <= item;
					drv_q[0] <= '0;
					drv_q[1] <= '0;
				end
			end
			S_DELTA: delta_q <= enc_sel - prev_enc_q[wheel_q];
			S_ERR:   err_q   <= EncW'(tgt_sel) - delta_q;
			S_MUL0: begin
				prod_q <= mul_res;
				derr_q <= DerrW'(err_q) - DerrW'(prev_err_q[wheel_q]);
			end
			S_MUL1: begin
				prod_q <= mul_res;
				acc_q  <= AccW'(prod_q);
			end
			S_MUL2: begin
				prod_q <= mul_res;
				acc_q  <= acc_q + AccW'(prod_q);
			end
			S_MUL3:  acc_q <= acc_q + AccW'(prod_q);
			S_ABS:   neg_q <= acc_q[AccW-1];
			S_NEG:   qs_q  <= neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
			S_CLAMP: begin
				if (sum_out >= lim_pos) begin
					drv_q[wheel_q] <= DrvW'(lim_pos);
				end else if (sum_out <= lim_neg) begin
					drv_q[wheel_q] <= DrvW'(lim_neg);
				end else begin
					drv_q[wheel_q] <= DrvW'(sum_out);
				end
			end
			default: ;
		endcase
	end

	assign stat.busy       = (state_q != S_IDLE);
	assign stat.done       = (state_q == S_DONE);
	assign res.drive_left  = drv_q[0];
	assign res.drive_right = drv_q[1];

endmodule

// ===== hdl/dual_wheel_incremental_pid_drive_top.sv =====
// Top level of the dual-wheel incremental PID drive block.
// Depends on dwpid_pkg, dwpid_if, dwpid_cfg_regs, dwpid_core and dwpid_div.
//
// Use: each beat on in_ch is one control tick carrying both encoder counts, both
// targets and the moving flag. Each tick yields exactly one beat on out_ch with the
// clamped signed drives and the H-bridge forward and reverse PWM levels per wheel.
// cfg_ch writes the gain, divisor and limit registers by index; it is always ready
// and must only be used while no tick is in flight. Unknown indexes are ignored.
//
// A moving tick works on each wheel in turn: S_DELTA and S_ERR for the error,
// S_MUL0 to S_MUL3 for the shared multiplier and accumulator, S_ABS to start the
// radix-4 divider, S_DIV waiting on its 26 steps, S_NEG for the sign and S_CLAMP
// for the clamp. The output register then takes the result once it is free. A tick
// with moving low gives an all-zero result and leaves the PID state alone. One tick
// is in work at a time; the input reopens once the result is in the output register.
//
// Reset clears the PID state of both wheels and loads the default gains. The result
// sits in an output register: in_ch accepts the next tick while that beat waits,
// and a stalled receiver holds the core only once a second result is ready.
module dual_wheel_incremental_pid_drive_top import dwpid_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	dwpid_in_if.sink   in_ch,
	dwpid_out_if.source out_ch,
	dwpid_cfg_if.sink  cfg_ch
);

	dwpid_cfg_t  cfg;
	dwpid_item_t item;
	dwpid_stat_t stat;
	dwpid_res_t  res;
	logic        start;
	logic        ack;

	logic                   out_valid_q;
	logic signed [DrvW-1:0] drive_left_q;
	logic signed [DrvW-1:0] drive_right_q;
	logic [PwmW-1:0]        left_rev_q, left_fwd_q, right_rev_q, right_fwd_q;

	assign cfg_ch.ready = 1'b1;

	dwpid_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_ch.valid),
		.wr_idx  (cfg_ch.index),
		.wr_data (cfg_ch.data),
		.cfg     (cfg)
	);

	assign item.enc_left     = in_ch.enc_left;
	assign item.enc_right    = in_ch.enc_right;
	assign item.target_left  = in_ch.target_left;
	assign item.target_right = in_ch.target_right;
	assign item.moving       = in_ch.moving;

	assign in_ch.ready = !stat.busy;
	assign start       = in_ch.valid && !stat.busy;
	assign ack         = stat.done && (!out_valid_q || out_ch.ready);

	dwpid_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.item   (item),
		.ack    (ack),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A negative drive goes to the reverse level as its magnitude, else to forward.
	always_ff @(posedge clk) begin
		if (ack) begin
			drive_left_q  <= res.drive_left;
			drive_right_q <= res.drive_right;
			left_rev_q    <= res.drive_left[DrvW-1]  ? PwmW'(-res.drive_left)  : '0;
			left_fwd_q    <= res.drive_left[DrvW-1]  ? '0 : res.drive_left[PwmW-1:0];
			right_rev_q   <= res.drive_right[DrvW-1] ? PwmW'(-res.drive_right) : '0;
			right_fwd_q   <= res.drive_right[DrvW-1] ? '0 : res.drive_right[PwmW-1:0];
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.drive_left    = drive_left_q;
	assign out_ch.drive_right   = drive_right_q;
	assign out_ch.left_reverse  = left_rev_q;
	assign out_ch.left_forward  = left_fwd_q;
	assign out_ch.right_reverse = right_rev_q;
	assign out_ch.right_forward = right_fwd_q;

endmodule

// ===== hdl/dwpid_checker.sv =====
// Port-level checks for the PID drive top level, attached by a bind statement.
// Depends on dwpid_pkg and dual_wheel_incremental_pid_drive_top.
module dwpid_checker import dwpid_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic signed [DrvW-1:0] drive_left,
	input logic signed [DrvW-1:0] drive_right,
	input logic [PwmW-1:0]        left_reverse,
	input logic [PwmW-1:0]        left_forward,
	input logic [PwmW-1:0]        right_reverse,
	input logic [PwmW-1:0]        right_forward
);

	// One tick in work at a time: an accepted beat closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted again right after a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drive_left)
			&& $stable(drive_right)))
		else $error("stalled result changed");

	a_left_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_left[DrvW-1]
			? (left_forward == '0 && left_reverse == PwmW'(~drive_left[PwmW-1:0] + 1'b1))
			: (left_reverse == '0 && left_forward == drive_left[PwmW-1:0])))
		else $error("left PWM levels disagree with drive");

	a_right_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_right[DrvW-1]
			? (right_forward == '0 && right_reverse == PwmW'(~drive_right[PwmW-1:0] + 1'b1))
			: (right_reverse == '0 && right_forward == drive_right[PwmW-1:0])))
		else $error("right PWM levels disagree with drive");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_left != 9'h100 && drive_right != 9'h100))
		else $error("drive outside the limit range");

endmodule

bind dual_wheel_incremental_pid_drive_top dwpid_checker u_dwpid_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.drive_left    (out_ch.drive_left),
	.drive_right   (out_ch.drive_right),
	.left_reverse  (out_ch.left_reverse),
	.left_forward  (out_ch.left_forward),
	.right_reverse (out_ch.right_reverse),
	.right_forward (out_ch.right_forward)
);

// ===== verif/dwpid_drive_checker.sv =====
// Checker for the dual-wheel PID drive block: watches the tick, drive and register channels,
// predicts every drive beat from its own copy of the gains and wheel state, and compares.
// Depends on dwpid_pkg and the channel interfaces of dwpid_if.
`timescale 1ns / 100ps

module dwpid_drive_checker import dwpid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dwpid_in_if  in_ch,
	dwpid_out_if out_ch,
	dwpid_cfg_if cfg_ch,
	output int   fail_count,
	output int   pending
);

	typedef struct {
		logic signed [DrvW-1:0] drive_left;
		logic signed [DrvW-1:0] drive_right;
		logic [PwmW-1:0]        left_reverse;
		logic [PwmW-1:0]        left_forward;
		logic [PwmW-1:0]        right_reverse;
		logic [PwmW-1:0]        right_forward;
	} drive_beat_t;

	dwpid_cfg_t      gains;
	logic [EncW-1:0] last_enc [2];
	logic [EncW-1:0] last_err [2];
	logic [EncW-1:0] err_sum [2];
	int              held_drive [2];
	drive_beat_t     drives_due [$];

	// One wheel's incremental PID update; returns the clamped drive.
	function automatic int wheel_step(int w, logic [EncW-1:0] enc, logic signed [TgtW-1:0] tgt);
		logic [EncW-1:0] moved;
		logic [EncW-1:0] err_bits;
		longint err, prev, integ, divisor, lim, sum, drive;
		moved    = enc - last_enc[w];
		err_bits = EncW'(tgt) - moved;
		err      = longint'($signed(err_bits));
		prev     = longint'($signed(last_err[w]));
		integ    = longint'($signed(err_sum[w]));
		divisor  = (gains.gain_divisor == '0) ? 64'sd1 : longint'(gains.gain_divisor);
		lim      = longint'(gains.max_output);
		sum = longint'(gains.gain_p) * err + longint'(gains.gain_d) * (err - prev)
			+ longint'(gains.gain_i) * integ;
		drive = sum / divisor + longint'(held_drive[w]);
		last_err[w] = err_bits;
		last_enc[w] = enc;
		if (drive >= lim) begin
			drive = lim;
		end else if (drive <= -lim) begin
			drive = -lim;
		end else begin
			err_sum[w] = err_sum[w] + err_bits;
		end
		held_drive[w] = int'(drive);
		return int'(drive);
	endfunction

	task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_beat_t want;
		int          dl, dr;
		if (!arst_n) begin
			gains.gain_p       = GainPRst;
			gains.gain_i       = GainIRst;
			gains.gain_d       = GainDRst;
			gains.gain_divisor = GainDivRst;
			gains.max_output   = MaxOutRst;
			for (int w = 0; w < 2; w++) begin
				last_enc[w]   = '0;
				last_err[w]   = '0;
				err_sum[w]    = '0;
				held_drive[w] = 0;
			end
			drives_due.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_GAIN_P:   gains.gain_p = cfg_ch.data;
					REG_GAIN_I:   gains.gain_i = cfg_ch.data;
					REG_GAIN_D:   gains.gain_d = cfg_ch.data;
					REG_GAIN_DIV: gains.gain_divisor = cfg_ch.data;
					REG_MAX_OUT:  gains.max_output = cfg_ch.data[LimW-1:0];
					default: ;
				endcase
			end

			if (out_ch.valid && out_ch.ready) begin
				if (drives_due.size() == 0) begin
					$error("drive beat with no tick waiting: drive_left %0d, drive_right %0d",
						out_ch.drive_left, out_ch.drive_right);
					fail_count++;
				end else begin
					want = drives_due.pop_front();
					check_field("drive_left", want.drive_left, out_ch.drive_left);
					check_field("drive_right", want.drive_right, out_ch.drive_right);
					check_field("left_reverse", want.left_reverse, out_ch.left_reverse);
					check_field("left_forward", want.left_forward, out_ch.left_forward);
					check_field("right_reverse", want.right_reverse, out_ch.right_reverse);
					check_field("right_forward", want.right_forward, out_ch.right_forward);
				end
			end

			// A stopped tick leaves the wheel state alone and drives nothing.
			if (in_ch.valid && in_ch.ready) begin
				dl = 0;
				dr = 0;
				if (in_ch.moving) begin
					dl = wheel_step(0, in_ch.enc_left, in_ch.target_left);
					dr = wheel_step(1, in_ch.enc_right, in_ch.target_right);
				end
				want.drive_left    = DrvW'(dl);
				want.drive_right   = DrvW'(dr);
				want.left_reverse  = (dl < 0) ? PwmW'(-dl) : '0;
				want.left_forward  = (dl >= 0) ? PwmW'(dl) : '0;
				want.right_reverse = (dr < 0) ? PwmW'(-dr) : '0;
				want.right_forward = (dr >= 0) ? PwmW'(dr) : '0;
				drives_due.push_back(want);
			end
			pending = drives_due.size();
		end
	end

endmodule

// ===== verif/tb_dual_wheel_incremental_pid_drive_top.sv =====
// Testbench top for the dual-wheel PID drive block: makes ticks, register writes and
// receiver stalls, and gives the verdict from the failure count of dwpid_drive_checker.
// Depends on dwpid_pkg, dwpid_if, the block's RTL and dwpid_drive_checker.
`timescale 1ns / 100ps

module tb_dual_wheel_incremental_pid_drive_top;
	import dwpid_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   stalls_on;
	int   fail_count;
	int   pending;

	// Encoder positions and targets of the well-formed tick stream.
	logic signed [EncW-1:0] pos_left, pos_right;
	logic signed [TgtW-1:0] aim_left, aim_right;

	dwpid_in_if  in_ch ();
	dwpid_out_if out_ch ();
	dwpid_cfg_if cfg_ch ();

	dual_wheel_incremental_pid_drive_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	dwpid_drive_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_ch     (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_tick(logic signed [EncW-1:0] el, logic signed [EncW-1:0] er,
		logic signed [TgtW-1:0] tl, logic signed [TgtW-1:0] tr, logic mv);
		if (stalls_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.enc_left     <= el;
		in_ch.enc_right    <= er;
		in_ch.target_left  <= tl;
		in_ch.target_right <= tr;
		in_ch.moving       <= mv;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Returns on a rising edge once every predicted beat has come out.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic load_gains(logic [CfgDataW-1:0] p, logic [CfgDataW-1:0] i,
		logic [CfgDataW-1:0] d, logic [CfgDataW-1:0] div, logic [CfgDataW-1:0] lim);
		wait_idle();
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_I, i);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_GAIN_DIV, div);
		write_reg(REG_MAX_OUT, lim);
		// Indexes past the last register must not disturb anything.
		for (int k = int'(REG_MAX_OUT) + 1; k < (1 << CfgIdxW); k++) begin
			write_reg(CfgIdxW'(k), CfgDataW'($urandom));
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly wheels that roughly follow their targets, with stopped ticks and
	// encoder jumps mixed in.
	task automatic random_ticks(int count);
		int pick, noise, pace;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_tick(EncW'($urandom), EncW'($urandom), TgtW'($urandom), TgtW'($urandom),
					1'b0);
			end else if (pick < 16) begin
				pos_left  = EncW'($urandom);
				pos_right = EncW'($urandom);
				send_tick(pos_left, pos_right, TgtW'($urandom), TgtW'($urandom), 1'b1);
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					aim_left  = TgtW'($urandom_range(0, 400) - 200);
					aim_right = TgtW'($urandom_range(0, 400) - 200);
					if ($urandom_range(0, 4) == 0) aim_left = TgtW'($urandom);
					if ($urandom_range(0, 4) == 0) aim_right = TgtW'($urandom);
				end
				pace  = $urandom_range(0, 5);
				noise = int'($urandom_range(0, 16)) - 8;
				pos_left += (aim_left * pace) / 4 + noise;
				pace  = $urandom_range(0, 5);
				noise = int'($urandom_range(0, 16)) - 8;
				pos_right += (aim_right * pace) / 4 + noise;
				send_tick(pos_left, pos_right, aim_left, aim_right, 1'b1);
			end
		end
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stalls_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		in_ch.valid        <= 1'b0;
		in_ch.enc_left     <= '0;
		in_ch.enc_right    <= '0;
		in_ch.target_left  <= '0;
		in_ch.target_right <= '0;
		in_ch.moving       <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_GAIN_P;
		cfg_ch.data        <= '0;
		stalls_on = 1'b1;
		pos_left  = '0;
		pos_right = '0;
		aim_left  = '0;
		aim_right = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default gains. A stopped tick first, so the state must stay at reset.
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, 1'b0);
		send_tick(32'sh0, 32'sh0, 16'sh0, 16'sh0, 1'b1);
		send_tick(32'sh0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_tick(32'sh0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b1);
		send_tick(32'sh1234_5678, 32'shDEAD_BEEF, 16'sh1111, 16'shEEEE, 1'b0);
		send_tick(32'sh1, -32'sh1, 16'sh1, -16'sh1, 1'b1);
		// Encoder changes of extreme size; the right error wraps past the signed range.
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh0, 16'sh0, 1'b1);
		send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh8000, 1'b1);
		send_tick(32'shFFFF_FFFF, 32'sh0, -16'sh1, 16'sh1, 1'b1);
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, 1'b1);
		send_tick(32'sh0000_FFFF, 32'shFFFF_0000, 16'sh5555, 16'shAAAA, 1'b1);
		send_tick(32'sh5555_5555, 32'shAAAA_AAAA, 16'sh8000, 16'sh7FFF, 1'b0);
		send_tick(32'sh0000_FFFF, 32'shFFFF_0000, 16'sh0, 16'sh0, 1'b1);
		send_tick(32'sh0, 32'sh0, 16'sh0, 16'sh0, 1'b1);
		random_ticks(200);

		// Largest gains with the smallest divisor: a moving tick saturates unless its terms cancel.
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'h00FF);
		send_tick(pos_left + 32'sd1, pos_right - 32'sd1, 16'sh0, 16'sh0, 1'b1);
		send_tick(pos_left, pos_right, 16'sh7FFF, 16'sh8000, 1'b1);
		send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF, 1'b1);
		pos_left  = 32'sh8000_0000;
		pos_right = 32'sh7FFF_FFFF;
		random_ticks(200);

		// Divisor of zero acts as one; a limit of zero holds both drives at zero.
		load_gains(16'd1, 16'd1, 16'd1, 16'd0, 16'hFF00);
		random_ticks(150);

		// No gain at all, largest divisor, smallest nonzero limit.
		load_gains(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h0001);
		random_ticks(150);

		for (int phase = 0; phase < 5; phase++) begin
			load_gains(CfgDataW'($urandom_range(0, 300)), CfgDataW'($urandom_range(0, 40)),
				CfgDataW'($urandom_range(0, 200)), CfgDataW'($urandom_range(1, 3000)),
				{8'($urandom), 8'($urandom_range(1, 255))});
			stalls_on = (phase != 2) && (phase != 4);
			random_ticks(240);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
